### rtl/avt_pkg.sv
// Package with payload types and constants of the affine vector transform core.
`timescale 1ns / 1ps

package avt_pkg;

	localparam int VEC_W = 32;
	localparam int NUM_ELEMS = 12;
	localparam int NUM_DIMS = 3;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_XFORM = 3'd1;
	localparam logic [2:0] OP_INV_XFORM = 3'd2;
	localparam logic [2:0] OP_ROTATE = 3'd3;
	localparam logic [2:0] OP_INV_ROTATE = 3'd4;

	localparam logic [3:0] ELEM_LIMIT = 4'd12;

	localparam logic signed [VEC_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [VEC_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] elem_index;
		logic signed [VEC_W-1:0] elem_value;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
	} avt_in_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] res_x;
		logic signed [VEC_W-1:0] res_y;
		logic signed [VEC_W-1:0] res_z;
		logic saturated;
	} avt_out_t;

endpackage

### rtl/affine_vector_transform_core.sv
// Top level of the affine vector transform core: a four-stage 3x4 matrix pipeline.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_ready, in_data) takes one beat per item. A beat
// either loads one element of the 3x4 matrix (rows 0 to 2 basis, row 3 translation)
// or transforms a vector in one of four modes. The output channel (out_valid,
// out_ready, out_data) carries one beat per transform; loads, out-of-range element
// indexes and unused op codes give no beat.
// A load takes effect at its acceptance edge, and every transform latches the
// matrix terms it needs at its own acceptance, so items see the matrix in order.
// The path is four register stages: operand select, translation subtract with
// saturation, nine 32x32 multiplies, then the sum and saturation into the output
// register. A result shows on out_valid once it reaches the output register.
// One item is accepted per cycle while the output side keeps up.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the matrix to identity with zero
// translation.

module affine_vector_transform_core #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input avt_pkg::avt_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output avt_pkg::avt_out_t out_data
);

	import avt_pkg::*;

	localparam int PROD_W = 2 * VEC_W - FRAC_BITS;
	localparam int SUM_W = PROD_W + 2;
	localparam logic signed [VEC_W-1:0] ONE_Q = VEC_W'(1) << FRAC_BITS;

	logic signed [VEC_W-1:0] m_q [NUM_ELEMS];

	logic advance;
	logic accept;
	logic is_xform;

	logic signed [VEC_W-1:0] vin [NUM_DIMS];
	logic signed [VEC_W-1:0] coef_c [NUM_DIMS][NUM_DIMS];
	logic signed [VEC_W-1:0] sub_c [NUM_DIMS];
	logic signed [VEC_W-1:0] add_c [NUM_DIMS];

	logic valid_s1;
	logic signed [VEC_W-1:0] v_s1 [NUM_DIMS];
	logic signed [VEC_W-1:0] sub_s1 [NUM_DIMS];
	logic signed [VEC_W-1:0] coef_s1 [NUM_DIMS][NUM_DIMS];
	logic signed [VEC_W-1:0] add_s1 [NUM_DIMS];

	logic signed [VEC_W:0] diff_c [NUM_DIMS];
	logic signed [VEC_W-1:0] iv_c [NUM_DIMS];
	logic [NUM_DIMS-1:0] dsat_c;

	logic valid_s2;
	logic sat_s2;
	logic signed [VEC_W-1:0] a_s2 [NUM_DIMS];
	logic signed [VEC_W-1:0] coef_s2 [NUM_DIMS][NUM_DIMS];
	logic signed [VEC_W-1:0] add_s2 [NUM_DIMS];

	logic signed [2*VEC_W-1:0] prod_c [NUM_DIMS][NUM_DIMS];

	logic valid_s3;
	logic sat_s3;
	logic signed [PROD_W-1:0] p_s3 [NUM_DIMS][NUM_DIMS];
	logic signed [VEC_W-1:0] add_s3 [NUM_DIMS];

	logic signed [SUM_W-1:0] sum_c [NUM_DIMS];
	logic signed [VEC_W-1:0] res_c [NUM_DIMS];
	logic [NUM_DIMS-1:0] ssat_c;

	assign advance = !out_valid || out_ready;
	assign in_ready = advance;
	assign accept = in_valid && in_ready;
	assign is_xform = (in_data.op == OP_XFORM) || (in_data.op == OP_INV_XFORM) ||
		(in_data.op == OP_ROTATE) || (in_data.op == OP_INV_ROTATE);

	assign vin[0] = in_data.vec_x;
	assign vin[1] = in_data.vec_y;
	assign vin[2] = in_data.vec_z;

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			for (int j = 0; j < NUM_DIMS; j++) begin
				if (in_data.op == OP_XFORM || in_data.op == OP_ROTATE) begin
					coef_c[i][j] = m_q[4'(j * NUM_DIMS + i)];
				end else begin
					coef_c[i][j] = m_q[4'(i * NUM_DIMS + j)];
				end
			end
			sub_c[i] = (in_data.op == OP_INV_XFORM) ? m_q[4'(9 + i)] : '0;
			add_c[i] = (in_data.op == OP_XFORM) ? m_q[4'(9 + i)] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ELEMS; k++) begin
				m_q[k] <= (k % (NUM_DIMS + 1) == 0) ? ONE_Q : '0;
			end
		end else if (accept && in_data.op == OP_LOAD && in_data.elem_index < ELEM_LIMIT) begin
			m_q[in_data.elem_index] <= in_data.elem_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && is_xform;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				v_s1[i] <= vin[i];
				sub_s1[i] <= sub_c[i];
				add_s1[i] <= add_c[i];
				for (int j = 0; j < NUM_DIMS; j++) begin
					coef_s1[i][j] <= coef_c[i][j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			diff_c[i] = (VEC_W + 1)'(v_s1[i]) - (VEC_W + 1)'(sub_s1[i]);
			dsat_c[i] = diff_c[i][VEC_W] != diff_c[i][VEC_W-1];
			if (dsat_c[i]) begin
				iv_c[i] = diff_c[i][VEC_W] ? Q_MIN : Q_MAX;
			end else begin
				iv_c[i] = diff_c[i][VEC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sat_s2 <= |dsat_c;
			for (int i = 0; i < NUM_DIMS; i++) begin
				a_s2[i] <= iv_c[i];
				add_s2[i] <= add_s1[i];
				for (int j = 0; j < NUM_DIMS; j++) begin
					coef_s2[i][j] <= coef_s1[i][j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			for (int j = 0; j < NUM_DIMS; j++) begin
				prod_c[i][j] = (2 * VEC_W)'(a_s2[j]) * (2 * VEC_W)'(coef_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sat_s3 <= sat_s2;
			for (int i = 0; i < NUM_DIMS; i++) begin
				add_s3[i] <= add_s2[i];
				for (int j = 0; j < NUM_DIMS; j++) begin
					p_s3[i][j] <= prod_c[i][j][2*VEC_W-1:FRAC_BITS];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			sum_c[i] = SUM_W'(p_s3[i][0]) + SUM_W'(p_s3[i][1]) + SUM_W'(p_s3[i][2]) +
				SUM_W'(add_s3[i]);
			ssat_c[i] = !((&sum_c[i][SUM_W-1:VEC_W-1]) || !(|sum_c[i][SUM_W-1:VEC_W-1]));
			if (ssat_c[i]) begin
				res_c[i] = sum_c[i][SUM_W-1] ? Q_MIN : Q_MAX;
			end else begin
				res_c[i] = sum_c[i][VEC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.res_x <= res_c[0];
			out_data.res_y <= res_c[1];
			out_data.res_z <= res_c[2];
			out_data.saturated <= sat_s3 || (|ssat_c);
		end
	end

endmodule

### rtl/avt_checker.sv
// Port-level checker for the affine vector transform core, with its bind.
`timescale 1ns / 1ps

module avt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input avt_pkg::avt_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input avt_pkg::avt_out_t out_data
);

	import avt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled output beat changed or dropped.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while no result was waiting.");

	a_ready_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("Input stalled while the waiting result was taken.");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("Input accepted while the pipeline was held.");

endmodule

bind affine_vector_transform_core avt_checker u_avt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

### tb/sv/affine_transform_checker.sv
// Result predictor and comparator for the affine vector transform core.
`timescale 1ns / 1ps

module affine_transform_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input avt_pkg::avt_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input avt_pkg::avt_out_t out_data,
	output int mismatches,
	output int pending_results
);

	import avt_pkg::*;

	logic signed [VEC_W-1:0] coef [NUM_ELEMS];
	avt_out_t expected_results [$];
	avt_out_t oldest;

	function automatic int elem_at(input int row, input int col);
		return row * NUM_DIMS + col;
	endfunction

	function automatic longint clamp_q(input longint x);
		if (x > Q_MAX) begin
			return Q_MAX;
		end
		if (x < Q_MIN) begin
			return Q_MIN;
		end
		return x;
	endfunction

	function automatic avt_out_t predict_result(input avt_in_t item);
		longint vin [NUM_DIMS];
		longint diff [NUM_DIMS];
		longint comp [NUM_DIMS];
		longint acc;
		longint prod;
		avt_out_t res;
		vin[0] = item.vec_x;
		vin[1] = item.vec_y;
		vin[2] = item.vec_z;
		res.saturated = 1'b0;
		if (item.op == OP_INV_XFORM) begin
			for (int c = 0; c < NUM_DIMS; c++) begin
				diff[c] = vin[c] - coef[elem_at(NUM_DIMS, c)];
				if (diff[c] != clamp_q(diff[c])) begin
					res.saturated = 1'b1;
				end
				diff[c] = clamp_q(diff[c]);
			end
		end
		for (int i = 0; i < NUM_DIMS; i++) begin
			acc = 0;
			for (int j = 0; j < NUM_DIMS; j++) begin
				case (item.op)
					OP_XFORM, OP_ROTATE: begin
						prod = vin[j] * coef[elem_at(j, i)];
					end
					OP_INV_ROTATE: begin
						prod = vin[j] * coef[elem_at(i, j)];
					end
					default: begin
						prod = diff[j] * coef[elem_at(i, j)];
					end
				endcase
				acc += prod >>> FRAC_BITS;
			end
			if (item.op == OP_XFORM) begin
				acc += coef[elem_at(NUM_DIMS, i)];
			end
			if (acc != clamp_q(acc)) begin
				res.saturated = 1'b1;
			end
			comp[i] = clamp_q(acc);
		end
		res.res_x = comp[0][VEC_W-1:0];
		res.res_y = comp[1][VEC_W-1:0];
		res.res_z = comp[2][VEC_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ELEMS; k++) begin
				coef[k] = '0;
			end
			for (int d = 0; d < NUM_DIMS; d++) begin
				coef[elem_at(d, d)] = 1 << FRAC_BITS;
			end
			expected_results.delete();
			mismatches = 0;
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat arrived with no transform outstanding");
				end else begin
					oldest = expected_results.pop_front();
					if (out_data.res_x !== oldest.res_x) begin
						report_mismatch($sformatf("res_x got %0d, expected %0d",
							out_data.res_x, oldest.res_x));
					end
					if (out_data.res_y !== oldest.res_y) begin
						report_mismatch($sformatf("res_y got %0d, expected %0d",
							out_data.res_y, oldest.res_y));
					end
					if (out_data.res_z !== oldest.res_z) begin
						report_mismatch($sformatf("res_z got %0d, expected %0d",
							out_data.res_z, oldest.res_z));
					end
					if (out_data.saturated !== oldest.saturated) begin
						report_mismatch($sformatf("saturated got %b, expected %b",
							out_data.saturated, oldest.saturated));
					end
				end
			end
			if (in_valid && in_ready) begin
				case (in_data.op)
					OP_LOAD: begin
						if (in_data.elem_index < ELEM_LIMIT) begin
							coef[in_data.elem_index] = in_data.elem_value;
						end
					end
					OP_XFORM, OP_INV_XFORM, OP_ROTATE, OP_INV_ROTATE: begin
						expected_results.push_back(predict_result(in_data));
					end
					default: begin
					end
				endcase
			end
			pending_results = expected_results.size();
		end
	end

endmodule

### tb/sv/affine_vector_transform_core_test.sv
// Top of the affine vector transform core testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module affine_vector_transform_core_test;

	import avt_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 1830;
	localparam int QUIET_ITEMS = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int TRANS_BASE = NUM_DIMS * NUM_DIMS;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [3:0] ELEM_TOP = 4'hf;
	localparam logic signed [VEC_W-1:0] Q_ONE = 1 << FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	avt_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	avt_out_t out_data;

	int mismatches;
	int pending_results;
	int effective_items = 0;
	int loop_count = 0;
	int roll;
	int send_idle_rate = 0;
	int recv_stall_rate = 0;
	int recv_cycles = 0;
	int idle_cycles = 0;
	bit quiet_tail = 1'b0;

	affine_vector_transform_core #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	affine_transform_checker #(
		.FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatches(mismatches),
		.pending_results(pending_results)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (recv_cycles % 256 == 0) begin
				recv_stall_rate = $urandom_range(0, 3);
			end
			recv_cycles++;
			if (!quiet_tail && $urandom_range(0, 15) < recv_stall_rate) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [VEC_W-1:0] rand_q();
		case ($urandom_range(0, 11))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4, 5: return $urandom;
			default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_item(input avt_in_t item);
		if (!quiet_tail && $urandom_range(0, 15) < send_idle_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (item.op == OP_LOAD ? item.elem_index < ELEM_LIMIT
				: (item.op >= OP_XFORM && item.op <= OP_INV_ROTATE)) begin
			effective_items++;
		end
		@(negedge clk);
	endtask

	task automatic send_load(input logic [3:0] idx, input logic signed [VEC_W-1:0] value);
		avt_in_t item;
		item.op = OP_LOAD;
		item.elem_index = idx;
		item.elem_value = value;
		item.vec_x = $urandom;
		item.vec_y = $urandom;
		item.vec_z = $urandom;
		send_item(item);
	endtask

	task automatic send_vector(input logic [2:0] op, input logic signed [VEC_W-1:0] x,
			input logic signed [VEC_W-1:0] y, input logic signed [VEC_W-1:0] z);
		avt_in_t item;
		item.op = op;
		item.elem_index = 4'($urandom_range(0, 15));
		item.elem_value = $urandom;
		item.vec_x = x;
		item.vec_y = y;
		item.vec_z = z;
		send_item(item);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Identity matrix, every mode, extreme vectors.
		send_vector(OP_XFORM, Q_MAX, Q_MIN, '0);
		send_vector(OP_INV_XFORM, Q_MAX, Q_MIN, '0);
		send_vector(OP_ROTATE, Q_MIN, Q_MAX, -1);
		send_vector(OP_INV_ROTATE, Q_MIN, Q_MAX, -1);
		// Extreme translation: sums and inverse differences clip.
		send_load(4'(TRANS_BASE), Q_MAX);
		send_load(4'(TRANS_BASE + 1), Q_MIN);
		send_load(4'(TRANS_BASE + 2), Q_ONE);
		send_vector(OP_XFORM, Q_MAX, Q_MIN, '0);
		send_vector(OP_INV_XFORM, Q_MIN, Q_MAX, Q_MIN);
		// Out-of-range loads and unused op codes must leave no trace.
		send_load(ELEM_LIMIT, Q_MIN);
		send_load(ELEM_TOP, Q_MAX);
		send_vector(OP_SPARE_LO, Q_MAX, Q_MAX, Q_MAX);
		send_vector(OP_SPARE_HI, Q_MIN, Q_MIN, Q_MIN);
		// Extreme basis values.
		send_load(4'd0, Q_MIN);
		send_load(4'(NUM_DIMS + 1), Q_MAX);
		send_load(4'(2 * (NUM_DIMS + 1)), -1);
		send_vector(OP_ROTATE, Q_MIN, Q_MIN, Q_MIN);
		send_vector(OP_INV_ROTATE, Q_MAX, -1, Q_MIN);
		// Tiny negative operands round toward minus infinity.
		send_vector(OP_XFORM, 1, -1, '0);
		send_vector(OP_SPARE_LO + 3'd1, '0, '0, '0);

		while (effective_items < RANDOM_ITEMS) begin
			quiet_tail = (effective_items >= RANDOM_ITEMS - QUIET_ITEMS);
			if (loop_count % 150 == 0) begin
				send_idle_rate = $urandom_range(0, 3);
			end
			loop_count++;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				for (int k = 0; k < NUM_ELEMS; k++) begin
					send_load(4'(k), rand_q());
				end
			end else if (roll < 20) begin
				send_load(4'($urandom_range(0, 15)), rand_q());
			end else if (roll < 24) begin
				send_vector(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
					rand_q(), rand_q(), rand_q());
			end else begin
				send_vector(3'($urandom_range(OP_XFORM, OP_INV_ROTATE)),
					rand_q(), rand_q(), rand_q());
			end
		end
		in_valid <= 1'b0;

		while (pending_results != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
